### hw/rtl/lfm_pkg.sv
// ----------------------------------------------------------------------------
// lfm_pkg
// Shared types and constants for the lattice fold Metropolis step engine:
// item command codes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lfm_pkg;

   localparam int CMD_W    = 2;
   localparam int IDX_W    = 6;
   localparam int POS_W    = 10;
   localparam int TYPE_W   = 5;
   localparam int CPL_W    = 12;
   localparam int PICK_W   = 4;
   localparam int THR_W    = 18;
   localparam int ENERGY_W = 19;
   localparam int DELTA_W  = 20;
   localparam int CLEN_W   = 7;
   localparam int ACC_W    = 33;

   localparam logic [CMD_W-1:0] CMD_LOAD_RES = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_CPL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MOVE     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ     = 2'd3;

   localparam logic [CLEN_W-1:0] CLEN_RESET = 7'd64;

   // Commands from the sequencer to the datapath, valid in the current cycle.
   typedef struct packed {
      logic take_item;    // latch payload, clear accumulators and flags
      logic load_wr;      // write residue at port A address
      logic cpl_wr_rc;    // write coupling at (row, col)
      logic cpl_wr_cr;    // write coupling at (col, row)
      logic pair_issue;   // port A/B read is an energy pair
      logic cap_self;     // capture moved residue from port A
      logic cap_prev;     // capture lower chain neighbor from port B
      logic cap_next;     // capture upper chain neighbor from port B
      logic has_prev;
      logic has_next;
      logic occ_clr;
      logic occ_issue;    // port A read is an occupancy probe
      logic cand_eval;    // resolve candidate mask and pick
      logic dl_issue;     // port B read contributes to the move delta
      logic commit;       // Metropolis decision and position write
      logic out_load;     // load result registers
      logic out_in_store; // residue index addresses the store
   } lfm_cmd_type;

   typedef struct packed {
      logic moved;
   } lfm_status_type;

endpackage

### hw/rtl/lfm_datapath.sv
// ----------------------------------------------------------------------------
// lfm_datapath
// Residue and coupling stores, the pair energy pipeline, candidate site
// evaluation, the Metropolis decision and the result registers.
// ----------------------------------------------------------------------------
module lfm_datapath #(
   parameter int MAX_RESIDUES = 64,
   parameter int AMINO_TYPES  = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lfm_pkg::lfm_cmd_type                   cmd,
   input  logic [$clog2(MAX_RESIDUES)-1:0]        addr_a,
   input  logic [$clog2(MAX_RESIDUES)-1:0]        addr_b,
   input  logic signed [lfm_pkg::POS_W-1:0]       req_pos_x,
   input  logic signed [lfm_pkg::POS_W-1:0]       req_pos_y,
   input  logic [lfm_pkg::TYPE_W-1:0]             req_residue_type,
   input  logic [lfm_pkg::TYPE_W-1:0]             req_type_row,
   input  logic [lfm_pkg::TYPE_W-1:0]             req_type_col,
   input  logic signed [lfm_pkg::CPL_W-1:0]       req_coupling,
   input  logic [lfm_pkg::PICK_W-1:0]             req_pick,
   input  logic [lfm_pkg::THR_W-1:0]              req_accept_threshold,
   output lfm_pkg::lfm_status_type                status,
   output logic                                   rsp_accepted,
   output logic                                   rsp_moved,
   output logic signed [lfm_pkg::POS_W-1:0]       rsp_new_x,
   output logic signed [lfm_pkg::POS_W-1:0]       rsp_new_y,
   output logic signed [lfm_pkg::ENERGY_W-1:0]    rsp_energy,
   output logic signed [lfm_pkg::DELTA_W-1:0]     rsp_delta_energy
);

   localparam int CDEPTH = AMINO_TYPES * AMINO_TYPES;
   localparam int CAW    = $clog2(CDEPTH);
   localparam int PW     = lfm_pkg::POS_W;
   localparam int TW     = lfm_pkg::TYPE_W;
   localparam int AW_ACC = lfm_pkg::ACC_W;

   localparam logic signed [AW_ACC-1:0] E_HI =
      AW_ACC'((2 ** (lfm_pkg::ENERGY_W - 1)) - 1);
   localparam logic signed [AW_ACC-1:0] E_LO = -E_HI - 1;
   localparam logic signed [AW_ACC-1:0] D_HI =
      AW_ACC'((2 ** (lfm_pkg::DELTA_W - 1)) - 1);
   localparam logic signed [AW_ACC-1:0] D_LO = -D_HI - 1;

   localparam logic signed [PW:0] DDX [4] = '{11'sd1, 11'sd1, -11'sd1, -11'sd1};
   localparam logic signed [PW:0] DDY [4] = '{11'sd1, -11'sd1, 11'sd1, -11'sd1};

   function automatic logic unit_apart(input logic signed [PW-1:0] ax,
                                       input logic signed [PW-1:0] ay,
                                       input logic signed [PW-1:0] bx,
                                       input logic signed [PW-1:0] by);
      logic signed [PW:0] dx;
      logic signed [PW:0] dy;
      dx = {ax[PW-1], ax} - {bx[PW-1], bx};
      dy = {ay[PW-1], ay} - {by[PW-1], by};
      return ((dx == '0) && ((dy == 11'sd1) || (dy == -11'sd1))) ||
             ((dy == '0) && ((dx == 11'sd1) || (dx == -11'sd1)));
   endfunction

   function automatic logic type_ok(input logic [TW-1:0] t);
      return (t != '0) && ({1'b0, t} <= 6'(AMINO_TYPES));
   endfunction

   function automatic logic [CAW-1:0] cpl_addr(input logic [TW-1:0] r,
                                               input logic [TW-1:0] c);
      logic [10:0] prod;
      prod = 11'(r - 5'd1) * 11'(AMINO_TYPES) + 11'(c - 5'd1);
      return prod[CAW-1:0];
   endfunction

   function automatic logic [1:0] mod3(input logic [lfm_pkg::PICK_W-1:0] v);
      logic [lfm_pkg::PICK_W-1:0] r;
      r = v;
      if (r >= 4'd12) r = r - 4'd12;
      if (r >= 4'd6)  r = r - 4'd6;
      if (r >= 4'd3)  r = r - 4'd3;
      return r[1:0];
   endfunction

   // Stores
   logic signed [PW-1:0] x_mem [MAX_RESIDUES];
   logic signed [PW-1:0] y_mem [MAX_RESIDUES];
   logic [TW-1:0]        t_mem [MAX_RESIDUES];
   logic signed [lfm_pkg::CPL_W-1:0] cpl_mem [CDEPTH];

   // Item payload
   logic signed [PW-1:0]              pos_x_ff, pos_y_ff;
   logic [TW-1:0]                     rtype_ff, trow_ff, tcol_ff;
   logic signed [lfm_pkg::CPL_W-1:0]  cpl_ff;
   logic [lfm_pkg::PICK_W-1:0]        pick_ff;
   logic [lfm_pkg::THR_W-1:0]         thr_ff;

   // Read ports
   logic signed [PW-1:0] rd_a_x_ff, rd_a_y_ff, rd_b_x_ff, rd_b_y_ff;
   logic [TW-1:0]        rd_a_t_ff, rd_b_t_ff;

   // Moved residue and its chain neighbors
   logic signed [PW-1:0] self_x_ff, self_y_ff, prev_x_ff, prev_y_ff;
   logic signed [PW-1:0] next_x_ff, next_y_ff, cand_x_ff, cand_y_ff;
   logic [TW-1:0]        self_t_ff;
   logic [3:0]           occ_ff, occ_in;

   // Pipeline control
   logic p1_pair_ff, p1_occ_ff, p1_dl_ff;
   logic s2_en_ff, s2_neg_ff, s2_dst_ff;
   logic signed [lfm_pkg::CPL_W-1:0] s2_cpl_ff;

   logic signed [AW_ACC-1:0] e_acc_ff, d_acc_ff;
   logic mov_ff, acc_ff, committed_ff;

   logic rsp_accepted_ff, rsp_moved_ff;
   logic signed [PW-1:0] rsp_new_x_ff, rsp_new_y_ff;
   logic signed [lfm_pkg::ENERGY_W-1:0] rsp_energy_ff;
   logic signed [lfm_pkg::DELTA_W-1:0]  rsp_delta_ff;

   // Stage 1: adjacency, weight and coupling address
   logic [TW-1:0]  s1_t1, s1_t2;
   logic           s1_en, s1_neg, s1_dst;
   logic [CAW-1:0] s1_addr;
   logic           adj_new, adj_old;

   always_comb begin
      adj_new = unit_apart(cand_x_ff, cand_y_ff, rd_b_x_ff, rd_b_y_ff);
      adj_old = unit_apart(self_x_ff, self_y_ff, rd_b_x_ff, rd_b_y_ff);
      s1_t1   = rd_a_t_ff;
      s1_t2   = rd_b_t_ff;
      s1_en   = 1'b0;
      s1_neg  = 1'b0;
      s1_dst  = 1'b0;
      if (p1_pair_ff) begin
         s1_en = unit_apart(rd_a_x_ff, rd_a_y_ff, rd_b_x_ff, rd_b_y_ff);
      end else if (p1_dl_ff) begin
         s1_t1  = self_t_ff;
         s1_en  = adj_new ^ adj_old;
         s1_neg = adj_old;
         s1_dst = 1'b1;
      end
      s1_en   = s1_en && type_ok(s1_t1) && type_ok(s1_t2);
      s1_addr = cpl_addr(s1_t1, s1_t2);
   end

   // Candidate sites
   logic signed [PW:0] cx [4];
   logic signed [PW:0] cy [4];
   logic [3:0] cand_mask;
   logic [2:0] cand_cnt;
   logic [1:0] cand_sel;
   logic [1:0] seen;
   logic signed [PW-1:0] pick_x, pick_y;

   always_comb begin
      occ_in    = occ_ff;
      cand_cnt  = '0;
      cand_mask = '0;
      for (int k = 0; k < 4; k++) begin
         cx[k] = {self_x_ff[PW-1], self_x_ff} + DDX[k];
         cy[k] = {self_y_ff[PW-1], self_y_ff} + DDY[k];
         if (p1_occ_ff && ({rd_a_x_ff[PW-1], rd_a_x_ff} == cx[k]) &&
             ({rd_a_y_ff[PW-1], rd_a_y_ff} == cy[k])) begin
            occ_in[k] = 1'b1;
         end
         cand_mask[k] = (cx[k][PW] == cx[k][PW-1]) && (cy[k][PW] == cy[k][PW-1]) &&
                        !occ_ff[k] &&
                        (!cmd.has_prev ||
                         unit_apart(cx[k][PW-1:0], cy[k][PW-1:0], prev_x_ff, prev_y_ff)) &&
                        (!cmd.has_next ||
                         unit_apart(cx[k][PW-1:0], cy[k][PW-1:0], next_x_ff, next_y_ff));
         cand_cnt = cand_cnt + 3'(cand_mask[k]);
      end
      if (cmd.occ_clr) occ_in = '0;
      case (cand_cnt)
         3'd2:    cand_sel = {1'b0, pick_ff[0]};
         3'd3:    cand_sel = mod3(pick_ff);
         3'd4:    cand_sel = pick_ff[1:0];
         default: cand_sel = 2'd0;
      endcase
      // walk to the cand_sel-th set bit
      seen   = '0;
      pick_x = cx[0][PW-1:0];
      pick_y = cy[0][PW-1:0];
      for (int k = 3; k >= 0; k--) begin
         if (cand_mask[k]) begin
            pick_x = cx[k][PW-1:0];
            pick_y = cy[k][PW-1:0];
         end
      end
      for (int k = 0; k < 4; k++) begin
         if (cand_mask[k]) begin
            if (seen == cand_sel) begin
               pick_x = cx[k][PW-1:0];
               pick_y = cy[k][PW-1:0];
            end
            seen = seen + 2'd1;
         end
      end
   end

   // Metropolis decision
   logic signed [AW_ACC-1:0] thr_ext;
   logic commit_ok, we_pos;
   logic signed [PW-1:0] wx, wy;

   always_comb begin
      thr_ext   = {{(AW_ACC - lfm_pkg::THR_W){1'b0}}, thr_ff};
      commit_ok = mov_ff && (d_acc_ff <= thr_ext);
      we_pos    = cmd.load_wr || (cmd.commit && commit_ok);
      wx        = cmd.load_wr ? pos_x_ff : cand_x_ff;
      wy        = cmd.load_wr ? pos_y_ff : cand_y_ff;
   end

   always_ff @(posedge clock) begin
      if (we_pos) begin
         x_mem[addr_a] <= wx;
         y_mem[addr_a] <= wy;
      end
      if (cmd.load_wr) begin
         t_mem[addr_a] <= rtype_ff;
      end
      rd_a_x_ff <= x_mem[addr_a];
      rd_a_y_ff <= y_mem[addr_a];
      rd_a_t_ff <= t_mem[addr_a];
      rd_b_x_ff <= x_mem[addr_b];
      rd_b_y_ff <= y_mem[addr_b];
      rd_b_t_ff <= t_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (type_ok(trow_ff) && type_ok(tcol_ff)) begin
         if (cmd.cpl_wr_rc) cpl_mem[cpl_addr(trow_ff, tcol_ff)] <= cpl_ff;
         if (cmd.cpl_wr_cr) cpl_mem[cpl_addr(tcol_ff, trow_ff)] <= cpl_ff;
      end
      s2_cpl_ff <= cpl_mem[s1_addr];
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         rtype_ff <= req_residue_type;
         trow_ff  <= req_type_row;
         tcol_ff  <= req_type_col;
         cpl_ff   <= req_coupling;
         pick_ff  <= req_pick;
         thr_ff   <= req_accept_threshold;
      end
      if (cmd.cap_self) begin
         self_x_ff <= rd_a_x_ff;
         self_y_ff <= rd_a_y_ff;
         self_t_ff <= rd_a_t_ff;
      end
      if (cmd.cap_prev) begin
         prev_x_ff <= rd_b_x_ff;
         prev_y_ff <= rd_b_y_ff;
      end
      if (cmd.cap_next) begin
         next_x_ff <= rd_b_x_ff;
         next_y_ff <= rd_b_y_ff;
      end
      if (cmd.cand_eval) begin
         cand_x_ff <= pick_x;
         cand_y_ff <= pick_y;
      end
      s2_neg_ff <= s1_neg;
      s2_dst_ff <= s1_dst;
      occ_ff    <= occ_in;
   end

   logic signed [AW_ACC-1:0] s2_term;
   assign s2_term = {{(AW_ACC - lfm_pkg::CPL_W){s2_cpl_ff[lfm_pkg::CPL_W-1]}}, s2_cpl_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_pair_ff   <= 1'b0;
         p1_occ_ff    <= 1'b0;
         p1_dl_ff     <= 1'b0;
         s2_en_ff     <= 1'b0;
         e_acc_ff     <= '0;
         d_acc_ff     <= '0;
         mov_ff       <= 1'b0;
         acc_ff       <= 1'b0;
         committed_ff <= 1'b0;
      end else begin
         p1_pair_ff <= cmd.pair_issue;
         p1_occ_ff  <= cmd.occ_issue;
         p1_dl_ff   <= cmd.dl_issue;
         s2_en_ff   <= s1_en;
         if (cmd.take_item) begin
            e_acc_ff     <= '0;
            d_acc_ff     <= '0;
            mov_ff       <= 1'b0;
            acc_ff       <= 1'b0;
            committed_ff <= 1'b0;
         end else begin
            if (s2_en_ff && !s2_dst_ff) begin
               e_acc_ff <= e_acc_ff + s2_term;
            end
            if (s2_en_ff && s2_dst_ff) begin
               d_acc_ff <= s2_neg_ff ? d_acc_ff - s2_term : d_acc_ff + s2_term;
            end
            if (cmd.cand_eval) begin
               mov_ff <= (cand_cnt != 3'd0);
            end
            if (cmd.commit) begin
               acc_ff       <= commit_ok || !mov_ff;
               committed_ff <= commit_ok;
            end
         end
      end
   end

   // Results
   logic signed [AW_ACC-1:0] e_tot;
   logic signed [AW_ACC-1:0] e_sat, d_sat;

   always_comb begin
      e_tot = e_acc_ff + (committed_ff ? d_acc_ff : '0);
      if (e_tot > E_HI)      e_sat = E_HI;
      else if (e_tot < E_LO) e_sat = E_LO;
      else                   e_sat = e_tot;
      if (d_acc_ff > D_HI)      d_sat = D_HI;
      else if (d_acc_ff < D_LO) d_sat = D_LO;
      else                      d_sat = d_acc_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_accepted_ff <= acc_ff;
         rsp_moved_ff    <= mov_ff;
         rsp_new_x_ff    <= cmd.out_in_store ? rd_a_x_ff : '0;
         rsp_new_y_ff    <= cmd.out_in_store ? rd_a_y_ff : '0;
         rsp_energy_ff   <= e_sat[lfm_pkg::ENERGY_W-1:0];
         rsp_delta_ff    <= d_sat[lfm_pkg::DELTA_W-1:0];
      end
   end

   assign status.moved     = mov_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_moved        = rsp_moved_ff;
   assign rsp_new_x        = rsp_new_x_ff;
   assign rsp_new_y        = rsp_new_y_ff;
   assign rsp_energy       = rsp_energy_ff;
   assign rsp_delta_energy = rsp_delta_ff;

endmodule

### hw/rtl/lfm_ctrl.sv
// ----------------------------------------------------------------------------
// lfm_ctrl
// Sequencer: item handshake, chain length register, pair and scan counters,
// and the command stream that drives the datapath.
// ----------------------------------------------------------------------------
module lfm_ctrl #(
   parameter int MAX_RESIDUES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lfm_pkg::CMD_W-1:0]           req_cmd,
   input  logic [lfm_pkg::IDX_W-1:0]           req_residue_index,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lfm_pkg::CLEN_W-1:0]          csr_chain_length,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  lfm_pkg::lfm_status_type             status,
   output lfm_pkg::lfm_cmd_type                cmd,
   output logic [$clog2(MAX_RESIDUES)-1:0]     addr_a,
   output logic [$clog2(MAX_RESIDUES)-1:0]     addr_b
);

   localparam int AW = $clog2(MAX_RESIDUES);
   localparam int NW = $clog2(MAX_RESIDUES + 1);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_WR_RES = 5'd1;
   localparam logic [4:0] S_WR_C0  = 5'd2;
   localparam logic [4:0] S_WR_C1  = 5'd3;
   localparam logic [4:0] S_WALK   = 5'd4;
   localparam logic [4:0] S_WDRAIN = 5'd5;
   localparam logic [4:0] S_MV_RD0 = 5'd6;
   localparam logic [4:0] S_MV_RD1 = 5'd7;
   localparam logic [4:0] S_MV_RD2 = 5'd8;
   localparam logic [4:0] S_SCAN   = 5'd9;
   localparam logic [4:0] S_SDRAIN = 5'd10;
   localparam logic [4:0] S_EVAL   = 5'd11;
   localparam logic [4:0] S_BR     = 5'd12;
   localparam logic [4:0] S_DL     = 5'd13;
   localparam logic [4:0] S_DDRAIN = 5'd14;
   localparam logic [4:0] S_CMT    = 5'd15;
   localparam logic [4:0] S_OUT_RD = 5'd16;
   localparam logic [4:0] S_OUT_LD = 5'd17;

   logic [4:0]                  state_ff, state_in;
   logic [lfm_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [lfm_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [NW-1:0]               i_ff, i_in, l_ff, l_in;
   logic                        drain_ff, drain_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lfm_pkg::CLEN_W-1:0]  clen_ff, clen_in;

   logic [10:0] clen_ext, n_ext, idx_ext, i_ext, l_ext, prev_ext, next_ext;
   logic        in_store, in_chain, take;

   always_comb begin
      clen_ext = 11'(clen_ff);
      if (clen_ext < 11'd2)                      n_ext = 11'd2;
      else if (clen_ext > 11'(MAX_RESIDUES))     n_ext = 11'(MAX_RESIDUES);
      else                                       n_ext = clen_ext;
      idx_ext  = 11'(idx_ff);
      i_ext    = 11'(i_ff);
      l_ext    = 11'(l_ff);
      prev_ext = idx_ext - 11'd1;
      next_ext = idx_ext + 11'd1;
      in_store = idx_ext < 11'(MAX_RESIDUES);
      in_chain = idx_ext < n_ext;
   end

   assign take      = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      i_in         = i_ff;
      l_in         = l_ff;
      drain_in     = drain_ff;
      clen_in      = clen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.take_item    = take;
      cmd.has_prev     = (idx_ff != '0);
      cmd.has_next     = next_ext < n_ext;
      cmd.out_in_store = in_store;
      addr_a = idx_ext[AW-1:0];
      addr_b = idx_ext[AW-1:0];

      if (csr_valid && csr_ready) clen_in = csr_chain_length;

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd_in = req_cmd;
               idx_in = req_residue_index;
               i_in   = '0;
               l_in   = NW'(2);
               if (req_cmd == lfm_pkg::CMD_LOAD_RES)      state_in = S_WR_RES;
               else if (req_cmd == lfm_pkg::CMD_LOAD_CPL) state_in = S_WR_C0;
               else                                       state_in = S_WALK;
            end
         end
         S_WR_RES: begin
            cmd.load_wr = in_store;
            state_in    = S_WALK;
         end
         S_WR_C0: begin
            cmd.cpl_wr_rc = 1'b1;
            state_in      = S_WR_C1;
         end
         S_WR_C1: begin
            cmd.cpl_wr_cr = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            addr_a = i_ff[AW-1:0];
            addr_b = l_ff[AW-1:0];
            cmd.pair_issue = (n_ext >= 11'd3);
            if (n_ext < 11'd3) begin
               state_in = S_WDRAIN;
            end else if (l_ext == n_ext - 11'd1) begin
               if (i_ext + 11'd3 >= n_ext) begin
                  state_in = S_WDRAIN;
               end else begin
                  i_in = i_ff + 1'b1;
                  l_in = NW'(i_ext + 11'd3);
               end
            end else begin
               l_in = l_ff + 1'b1;
            end
         end
         S_WDRAIN: begin
            if (cmd_ff == lfm_pkg::CMD_MOVE && in_chain) state_in = S_MV_RD0;
            else                                         state_in = S_OUT_RD;
         end
         S_MV_RD0: begin
            addr_b   = prev_ext[AW-1:0];
            state_in = S_MV_RD1;
         end
         S_MV_RD1: begin
            addr_b       = next_ext[AW-1:0];
            cmd.cap_self = 1'b1;
            cmd.cap_prev = 1'b1;
            cmd.occ_clr  = 1'b1;
            l_in         = '0;
            state_in     = S_MV_RD2;
         end
         S_MV_RD2: begin
            cmd.cap_next = 1'b1;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            addr_a        = l_ff[AW-1:0];
            cmd.occ_issue = 1'b1;
            if (l_ext == n_ext - 11'd1) begin
               l_in     = '0;
               state_in = S_SDRAIN;
            end else begin
               l_in = l_ff + 1'b1;
            end
         end
         S_SDRAIN: state_in = S_EVAL;
         S_EVAL: begin
            cmd.cand_eval = 1'b1;
            state_in      = S_BR;
         end
         S_BR: begin
            state_in = status.moved ? S_DL : S_CMT;
         end
         S_DL: begin
            addr_b       = l_ff[AW-1:0];
            // skip the residue itself and its bonded neighbors
            cmd.dl_issue = (l_ext + 11'd2 <= idx_ext) || (l_ext >= idx_ext + 11'd2);
            if (l_ext == n_ext - 11'd1) begin
               drain_in = 1'b1;
               state_in = S_DDRAIN;
            end else begin
               l_in = l_ff + 1'b1;
            end
         end
         S_DDRAIN: begin
            if (drain_ff) drain_in = 1'b0;
            else          state_in = S_CMT;
         end
         S_CMT: begin
            cmd.commit = 1'b1;
            state_in   = S_OUT_RD;
         end
         S_OUT_RD: state_in = S_OUT_LD;
         S_OUT_LD: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         clen_ff      <= lfm_pkg::CLEN_RESET;
         drain_ff     <= 1'b0;
         i_ff         <= '0;
         l_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clen_ff      <= clen_in;
         drain_ff     <= drain_in;
         i_ff         <= i_in;
         l_ff         <= l_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
   end

`ifndef SYNTHESIS
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after taking an item");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && n_ext >= 11'd3) |->
         (l_ext >= i_ext + 11'd2 && l_ext < n_ext))
      else $error("pair walk indices out of range");

   a_delta_needs_move: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DL) |-> status.moved)
      else $error("delta walk without a candidate");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !(cmd.pair_issue || cmd.occ_issue || cmd.dl_issue ||
                                 cmd.load_wr || cmd.commit))
      else $error("datapath command issued while idle");
`endif

endmodule

### hw/rtl/lattice_fold_metropolis_step.sv
// ----------------------------------------------------------------------------
// lattice_fold_metropolis_step
// Metropolis Monte Carlo step engine for a residue chain on a 2D lattice.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per handshake: load residue, load coupling entry,
//            try a diagonal move of a residue, or read the chain energy.
//   rsp_*  : exactly one result item per request item, in order.
//   csr_*  : chain length register, to be written by the user only while the
//            block is idle; the block itself has no guard for it.
// Flow, with n the active chain length: every item runs the pair energy walk
//   over the (n-1)(n-2)/2 non-bonded residue pairs, one residue pair a cycle
//   through the two store read ports and the coupling table.
//   One item is in work at a time; the next is taken once its result sits
//   in the result register, even if that result is not yet taken.
// Reset: control state clears, chain length returns to 64; the residue and
//   coupling stores keep no reset value and must be loaded before use.
// Stall: while rsp_ready is low the finished result holds and a following
//   item completes its work and then waits for the register to drain.
// ----------------------------------------------------------------------------
module lattice_fold_metropolis_step #(
   parameter int MAX_RESIDUES = 64,
   parameter int AMINO_TYPES  = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lfm_pkg::CMD_W-1:0]           req_cmd,
   input  logic [lfm_pkg::IDX_W-1:0]           req_residue_index,
   input  logic signed [lfm_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [lfm_pkg::POS_W-1:0]    req_pos_y,
   input  logic [lfm_pkg::TYPE_W-1:0]          req_residue_type,
   input  logic [lfm_pkg::TYPE_W-1:0]          req_type_row,
   input  logic [lfm_pkg::TYPE_W-1:0]          req_type_col,
   input  logic signed [lfm_pkg::CPL_W-1:0]    req_coupling,
   input  logic [lfm_pkg::PICK_W-1:0]          req_pick,
   input  logic [lfm_pkg::THR_W-1:0]           req_accept_threshold,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic                                rsp_moved,
   output logic signed [lfm_pkg::POS_W-1:0]    rsp_new_x,
   output logic signed [lfm_pkg::POS_W-1:0]    rsp_new_y,
   output logic signed [lfm_pkg::ENERGY_W-1:0] rsp_energy,
   output logic signed [lfm_pkg::DELTA_W-1:0]  rsp_delta_energy,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lfm_pkg::CLEN_W-1:0]          csr_chain_length
);

   lfm_pkg::lfm_cmd_type               cmd;
   lfm_pkg::lfm_status_type            status;
   logic [$clog2(MAX_RESIDUES)-1:0]    addr_a, addr_b;

   lfm_ctrl #(
      .MAX_RESIDUES(MAX_RESIDUES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_residue_index (req_residue_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_chain_length  (csr_chain_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .status            (status),
      .cmd               (cmd),
      .addr_a            (addr_a),
      .addr_b            (addr_b)
   );

   lfm_datapath #(
      .MAX_RESIDUES(MAX_RESIDUES),
      .AMINO_TYPES (AMINO_TYPES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .addr_a               (addr_a),
      .addr_b               (addr_b),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_residue_type     (req_residue_type),
      .req_type_row         (req_type_row),
      .req_type_col         (req_type_col),
      .req_coupling         (req_coupling),
      .req_pick             (req_pick),
      .req_accept_threshold (req_accept_threshold),
      .status               (status),
      .rsp_accepted         (rsp_accepted),
      .rsp_moved            (rsp_moved),
      .rsp_new_x            (rsp_new_x),
      .rsp_new_y            (rsp_new_y),
      .rsp_energy           (rsp_energy),
      .rsp_delta_energy     (rsp_delta_energy)
   );

endmodule

### tb/lattice_fold_metropolis_step_tb.sv
// ----------------------------------------------------------------------------
// lattice_fold_metropolis_step_tb
// Self-checking bench for the lattice Metropolis step engine. Loads every
// residue and coupling entry at a two-residue chain length, walks a short
// table of edge cases, then runs phases of random chains at several chain
// lengths. Results are checked against a local model and fixed table rows.
// ----------------------------------------------------------------------------
module lattice_fold_metropolis_step_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NRES           = 64;
   localparam int NTYPES         = 20;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 100;
   localparam int MAX_REPORTS    = 10;

   localparam int CMD_BITS    = lfm_pkg::CMD_W;
   localparam int IDX_BITS    = lfm_pkg::IDX_W;
   localparam int POS_BITS    = lfm_pkg::POS_W;
   localparam int TYPE_BITS   = lfm_pkg::TYPE_W;
   localparam int CPL_BITS    = lfm_pkg::CPL_W;
   localparam int PICK_BITS   = lfm_pkg::PICK_W;
   localparam int THR_BITS    = lfm_pkg::THR_W;
   localparam int ENERGY_BITS = lfm_pkg::ENERGY_W;
   localparam int DELTA_BITS  = lfm_pkg::DELTA_W;
   localparam int CLEN_BITS   = lfm_pkg::CLEN_W;

   typedef struct {
      logic [CMD_BITS-1:0]         cmd;
      logic [IDX_BITS-1:0]         idx;
      logic signed [POS_BITS-1:0]  px;
      logic signed [POS_BITS-1:0]  py;
      logic [TYPE_BITS-1:0]        rtype;
      logic [TYPE_BITS-1:0]        trow;
      logic [TYPE_BITS-1:0]        tcol;
      logic signed [CPL_BITS-1:0]  cpl;
      logic [PICK_BITS-1:0]        pick;
      logic [THR_BITS-1:0]         thr;
   } step_item_type;

   typedef struct {
      logic                          acc;
      logic                          mov;
      logic signed [POS_BITS-1:0]    nx;
      logic signed [POS_BITS-1:0]    ny;
      logic signed [ENERGY_BITS-1:0] en;
      logic signed [DELTA_BITS-1:0]  de;
   } step_result_type;

   typedef struct {
      step_item_type it;
      bit            fixed;
      logic          acc;
      logic          mov;
   } edge_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CMD_BITS-1:0] req_cmd = '0;
   logic [IDX_BITS-1:0] req_residue_index = '0;
   logic signed [POS_BITS-1:0] req_pos_x = '0;
   logic signed [POS_BITS-1:0] req_pos_y = '0;
   logic [TYPE_BITS-1:0] req_residue_type = '0;
   logic [TYPE_BITS-1:0] req_type_row = '0;
   logic [TYPE_BITS-1:0] req_type_col = '0;
   logic signed [CPL_BITS-1:0] req_coupling = '0;
   logic [PICK_BITS-1:0] req_pick = '0;
   logic [THR_BITS-1:0] req_accept_threshold = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_accepted;
   logic rsp_moved;
   logic signed [POS_BITS-1:0] rsp_new_x;
   logic signed [POS_BITS-1:0] rsp_new_y;
   logic signed [ENERGY_BITS-1:0] rsp_energy;
   logic signed [DELTA_BITS-1:0] rsp_delta_energy;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CLEN_BITS-1:0] csr_chain_length = '0;

   lattice_fold_metropolis_step uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_residue_index(req_residue_index),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_residue_type(req_residue_type),
      .req_type_row(req_type_row), .req_type_col(req_type_col),
      .req_coupling(req_coupling), .req_pick(req_pick),
      .req_accept_threshold(req_accept_threshold),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted), .rsp_moved(rsp_moved),
      .rsp_new_x(rsp_new_x), .rsp_new_y(rsp_new_y),
      .rsp_energy(rsp_energy), .rsp_delta_energy(rsp_delta_energy),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_chain_length(csr_chain_length)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // lattice model state
   int site_x [NRES];
   int site_y [NRES];
   int site_t [NRES];
   int coupling_mat [NTYPES*NTYPES];
   int chain_len_q = 64;

   step_result_type pending_results [$];
   bit idle_on = 1'b0;
   int errors = 0;
   int items_sent = 0;
   int moves_sent = 0;
   int results_seen = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   function automatic int active_n();
      int n;
      n = chain_len_q;
      if (n < 2) n = 2;
      if (n > NRES) n = NRES;
      return n;
   endfunction

   function automatic int type_coupling(int a, int b);
      if (a < 1 || a > NTYPES || b < 1 || b > NTYPES) return 0;
      return coupling_mat[(a-1)*NTYPES + (b-1)];
   endfunction

   function automatic bit adjacent(int ax, int ay, int bx, int by);
      return (ax-bx)*(ax-bx) + (ay-by)*(ay-by) == 1;
   endfunction

   // mi < 0: no residue displaced
   function automatic longint contact_energy(int mi, int mx, int my);
      int n, ix, iy, lx, ly;
      longint e;
      n = active_n();
      e = 0;
      for (int i = 0; i < n; i++) begin
         ix = (i == mi) ? mx : site_x[i];
         iy = (i == mi) ? my : site_y[i];
         for (int l = i + 2; l < n; l++) begin
            lx = (l == mi) ? mx : site_x[l];
            ly = (l == mi) ? my : site_y[l];
            if (adjacent(ix, iy, lx, ly)) e += type_coupling(site_t[i], site_t[l]);
         end
      end
      return e;
   endfunction

   function automatic longint clip(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w-1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic step_result_type predict_step(step_item_type it);
      step_result_type r;
      int idx, n, cnt, px, py, c, rr, cc;
      int cx [4];
      int cy [4];
      bit ok;
      longint delta;
      idx = int'(it.idx);
      n = active_n();
      delta = 0;
      r.acc = 1'b0;
      r.mov = 1'b0;
      case (it.cmd)
         lfm_pkg::CMD_LOAD_RES: begin
            site_x[idx] = int'(it.px);
            site_y[idx] = int'(it.py);
            site_t[idx] = int'(it.rtype);
         end
         lfm_pkg::CMD_LOAD_CPL: begin
            rr = int'(it.trow);
            cc = int'(it.tcol);
            if (rr >= 1 && rr <= NTYPES && cc >= 1 && cc <= NTYPES) begin
               coupling_mat[(rr-1)*NTYPES + (cc-1)] = int'(it.cpl);
               coupling_mat[(cc-1)*NTYPES + (rr-1)] = int'(it.cpl);
            end
         end
         lfm_pkg::CMD_MOVE: begin
            if (idx < n) begin
               cnt = 0;
               for (int k = 0; k < 4; k++) begin
                  px = site_x[idx] + ((k < 2) ? 1 : -1);
                  py = site_y[idx] + ((k % 2 == 0) ? 1 : -1);
                  ok = px >= -512 && px <= 511 && py >= -512 && py <= 511;
                  for (int j = 0; j < n; j++)
                     if (site_x[j] == px && site_y[j] == py) ok = 1'b0;
                  if (ok && idx > 0 && !adjacent(px, py, site_x[idx-1], site_y[idx-1]))
                     ok = 1'b0;
                  if (ok && idx + 1 < n &&
                      !adjacent(px, py, site_x[idx+1], site_y[idx+1]))
                     ok = 1'b0;
                  if (ok) begin
                     cx[cnt] = px;
                     cy[cnt] = py;
                     cnt++;
                  end
               end
               if (cnt == 0) begin
                  r.acc = 1'b1;
               end else begin
                  c = int'(it.pick) % cnt;
                  delta = contact_energy(idx, cx[c], cy[c]) - contact_energy(-1, 0, 0);
                  r.mov = 1'b1;
                  if (delta <= longint'(it.thr)) begin
                     site_x[idx] = cx[c];
                     site_y[idx] = cy[c];
                     r.acc = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      r.nx = site_x[idx][POS_BITS-1:0];
      r.ny = site_y[idx][POS_BITS-1:0];
      r.en = ENERGY_BITS'(clip(contact_energy(-1, 0, 0), ENERGY_BITS));
      r.de = DELTA_BITS'(clip(delta, DELTA_BITS));
      return r;
   endfunction

   function automatic step_item_type rand_item(logic [CMD_BITS-1:0] cmd, int idx);
      step_item_type it;
      it.cmd   = cmd;
      it.idx   = IDX_BITS'(idx);
      it.px    = POS_BITS'($urandom);
      it.py    = POS_BITS'($urandom);
      it.rtype = TYPE_BITS'($urandom);
      it.trow  = TYPE_BITS'($urandom);
      it.tcol  = TYPE_BITS'($urandom);
      it.cpl   = CPL_BITS'($urandom);
      it.pick  = PICK_BITS'($urandom);
      it.thr   = THR_BITS'($urandom);
      return it;
   endfunction

   function automatic edge_row_type mk(logic [CMD_BITS-1:0] cmd, int idx, int px, int py,
                                       int rtype, int trow, int tcol, int cpl, int pick,
                                       int thr, bit fixed, logic acc, logic mov);
      edge_row_type row;
      row.it = rand_item(cmd, idx);
      row.it.px = POS_BITS'(px);
      row.it.py = POS_BITS'(py);
      row.it.rtype = TYPE_BITS'(rtype);
      row.it.trow = TYPE_BITS'(trow);
      row.it.tcol = TYPE_BITS'(tcol);
      row.it.cpl = CPL_BITS'(cpl);
      row.it.pick = PICK_BITS'(pick);
      row.it.thr = THR_BITS'(thr);
      row.fixed = fixed;
      row.acc = acc;
      row.mov = mov;
      return row;
   endfunction

   task automatic send_step(step_item_type it, bit fixed = 1'b0,
                            logic facc = 1'b0, logic fmov = 1'b0);
      step_result_type r;
      if (idle_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 13)) @(negedge clock);
      req_cmd = it.cmd;
      req_residue_index = it.idx;
      req_pos_x = it.px;
      req_pos_y = it.py;
      req_residue_type = it.rtype;
      req_type_row = it.trow;
      req_type_col = it.tcol;
      req_coupling = it.cpl;
      req_pick = it.pick;
      req_accept_threshold = it.thr;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      r = predict_step(it);
      if (fixed) begin
         r.acc = facc;
         r.mov = fmov;
         r.de = '0;
      end
      pending_results = {pending_results, r};
      items_sent++;
      if (it.cmd == lfm_pkg::CMD_MOVE) moves_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain_results();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_chain_length(int v);
      drain_results();
      csr_chain_length = CLEN_BITS'(v);
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      chain_len_q = v & 'h7f;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // self-avoiding walk of n residues loaded from index 0
   task automatic build_chain(int n, int ox, int oy);
      int bx [NRES];
      int by [NRES];
      int tries, d, nx, ny;
      bit ok, placed;
      step_item_type it;
      tries = 0;
      bx[0] = ox;
      by[0] = oy;
      for (int i = 1; i < n; i++) begin
         placed = 1'b0;
         for (int a = 0; a < 12 && !placed; a++) begin
            d = int'($urandom_range(0, 3));
            nx = bx[i-1] + ((d == 0) ? 1 : 0) - ((d == 1) ? 1 : 0);
            ny = by[i-1] + ((d == 2) ? 1 : 0) - ((d == 3) ? 1 : 0);
            ok = nx >= -512 && nx <= 511 && ny >= -512 && ny <= 511;
            for (int j = 0; j < i; j++)
               if (bx[j] == nx && by[j] == ny) ok = 1'b0;
            if (ok) begin
               bx[i] = nx;
               by[i] = ny;
               placed = 1'b1;
            end
         end
         if (!placed) begin
            // stuck: restart the walk, fall back to a straight run
            tries++;
            i = 0;
            if (tries > 40) begin
               for (int j = 1; j < n; j++) begin
                  bx[j] = 0;
                  by[j] = j - 32;
               end
               i = n;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         it = rand_item(lfm_pkg::CMD_LOAD_RES, i);
         it.px = POS_BITS'(bx[i]);
         it.py = POS_BITS'(by[i]);
         it.rtype = TYPE_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(1, NTYPES));
         send_step(it);
      end
   endtask

   task automatic run_phase(int len_cfg, int count);
      int n, sel, ox, oy;
      step_item_type it;
      write_chain_length(len_cfg);
      n = active_n();
      ox = ($urandom_range(0, 7) == 0) ? 511 - int'($urandom_range(0, 4))
                                       : int'($urandom_range(0, 960)) - 480;
      oy = ($urandom_range(0, 7) == 0) ? -512 + int'($urandom_range(0, 4))
                                       : int'($urandom_range(0, 960)) - 480;
      build_chain(n, ox, oy);
      for (int k = 0; k < count; k++) begin
         sel = int'($urandom_range(0, 99));
         if (sel < 65) begin
            it = rand_item(lfm_pkg::CMD_MOVE, int'($urandom_range(0, n-1)));
            case ($urandom_range(0, 2))
               0: it.thr = '0;
               1: it.thr = THR_BITS'($urandom_range(0, 3000));
               default: ;
            endcase
         end else if (sel < 72) begin
            it = rand_item(lfm_pkg::CMD_MOVE, int'($urandom_range(0, NRES-1)));
         end else if (sel < 80) begin
            it = rand_item(lfm_pkg::CMD_READ, int'($urandom_range(0, NRES-1)));
         end else if (sel < 87) begin
            it = rand_item(lfm_pkg::CMD_LOAD_CPL, int'($urandom_range(0, NRES-1)));
            if ($urandom_range(0, 4) != 0) begin
               it.trow = TYPE_BITS'($urandom_range(1, NTYPES));
               it.tcol = TYPE_BITS'($urandom_range(1, NTYPES));
            end
         end else if (sel < 93) begin
            it = rand_item(lfm_pkg::CMD_LOAD_RES, int'($urandom_range(0, n-1)));
         end else begin
            it = rand_item(lfm_pkg::CMD_LOAD_RES, int'($urandom_range(0, NRES-1)));
         end
         send_step(it);
         if ($urandom_range(0, 49) == 0) build_chain(n, ox, oy);
      end
   endtask

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = int'($urandom_range(1, 13)) - 1;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      step_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) $display("unexpected result item at %0t", $realtime);
         end else begin
            e = pending_results.pop_front();
            if (rsp_accepted !== e.acc || rsp_moved !== e.mov || rsp_new_x !== e.nx ||
                rsp_new_y !== e.ny || rsp_energy !== e.en || rsp_delta_energy !== e.de) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display({"mismatch %0t: exp acc %0d mov %0d x %0d y %0d e %0d d %0d,",
                            " got acc %0d mov %0d x %0d y %0d e %0d d %0d"},
                           $realtime, e.acc, e.mov, e.nx, e.ny, e.en, e.de,
                           rsp_accepted, rsp_moved, rsp_new_x, rsp_new_y,
                           rsp_energy, rsp_delta_energy);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("lattice_fold_metropolis_step_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      edge_row_type rows [$];
      step_item_type it;
      int lens [12] = '{64, 0, 3, 127, 2, 5, 10, 16, 20, 8, 4, 12};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // two-residue chain: no contact pairs, so loading never reads an empty entry
      write_chain_length(2);
      build_chain(NRES, 0, 0);
      for (int r = 1; r <= NTYPES; r++)
         for (int c = r; c <= NTYPES; c++) begin
            it = rand_item(lfm_pkg::CMD_LOAD_CPL, 0);
            it.trow = TYPE_BITS'(r);
            it.tcol = TYPE_BITS'(c);
            send_step(it);
         end

      rows = {rows, mk(lfm_pkg::CMD_LOAD_RES, 63, -512, -512, 31, 0, 0, 0, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_RES, 62, 511, 511, 0, 0, 0, 0, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_RES, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_RES, 1, 1, 0, 20, 0, 0, 0, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_CPL, 0, 0, 0, 0, 0, 5, 100, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_CPL, 0, 0, 0, 0, 21, 20, -5, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_CPL, 0, 0, 0, 0, 31, 31, 7, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_CPL, 0, 0, 0, 0, 20, 20, -2048, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_CPL, 0, 0, 0, 0, 1, 20, 2047, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_READ, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      // inactive residue: reported as a plain read
      rows = {rows, mk(lfm_pkg::CMD_MOVE, 63, 0, 0, 0, 0, 0, 0, 15, 'h3ffff, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_MOVE, 1, 0, 0, 0, 0, 0, 0, 3, 0, 1, 1, 1)};
      rows = {rows, mk(lfm_pkg::CMD_MOVE, 0, 0, 0, 0, 0, 0, 0, 15, 'h3ffff, 0, 0, 0)};
      // neighbor two sites away: no candidate
      rows = {rows, mk(lfm_pkg::CMD_LOAD_RES, 0, 0, 0, 3, 0, 0, 0, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_RES, 1, 2, 0, 5, 0, 0, 0, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_MOVE, 0, 0, 0, 0, 0, 0, 0, 11, 0, 1, 1, 0)};
      // candidates off the coordinate range at both edges
      rows = {rows, mk(lfm_pkg::CMD_LOAD_RES, 0, 511, 0, 2, 0, 0, 0, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_RES, 1, 510, 0, 2, 0, 0, 0, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_MOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1)};
      rows = {rows, mk(lfm_pkg::CMD_MOVE, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_RES, 0, -512, -512, 4, 0, 0, 0, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_LOAD_RES, 1, -511, -512, 4, 0, 0, 0, 0, 0, 1, 0, 0)};
      rows = {rows, mk(lfm_pkg::CMD_MOVE, 0, 0, 0, 0, 0, 0, 0, 2, 0, 1, 1, 1)};
      foreach (rows[i]) send_step(rows[i].it, rows[i].fixed, rows[i].acc, rows[i].mov);

      idle_on = 1'b1;
      foreach (lens[p]) begin
         if (p == $size(lens) - 1) idle_on = 1'b0;
         run_phase(lens[p], (lens[p] >= NRES) ? 20 : 25);
      end

      while (pending_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) errors++;
      $display("sent %0d items (%0d moves), checked %0d results over %0d chain lengths",
               items_sent, moves_sent, results_seen, $size(lens) + 1);
      $display("mismatches: %0d", errors);
      if (errors == 0) begin
         $display("lattice_fold_metropolis_step_tb OK");
      end else begin
         $display("lattice_fold_metropolis_step_tb NOT OK");
      end
      $finish;
   end

endmodule
